FILE: hw/rtl/assert_macros.svh
// assertion macros used by go_to_goal_controller_unit
// depends on nothing; define SYNTH to drop the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define GGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define GGC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GGC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/ggc_pkg.sv
// types, constants and tables of the go-to-goal controller
// depends on nothing
`default_nettype none
package ggc_pkg;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_IW = $clog2(CORDIC_ITERATIONS);
    localparam int CW = 37;
    localparam int ZW = 20;
    localparam int HALF_PI_Q16 = 102944;
    localparam int SQ_W = 64;
    localparam int SQ_STEPS = 32;
    localparam int SQ_CW = $clog2(SQ_STEPS);
    localparam int MW = 34;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 23;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TOL  = 3'd0,
        CFG_RAD  = 3'd1,
        CFG_MAX  = 3'd2,
        CFG_GAIN = 3'd3,
        CFG_OFS  = 3'd4,
        CFG_TURN = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_QMUL, S_YAW, S_BRG, S_CMP, S_ABS, S_MMUL, S_SQRT, S_SPD, S_OUT
    } t_state;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [CORDIC_IW-1:0] i);
        logic signed [ZW-1:0] v;
        case (32'(i))
            0:  v = ZW'(51472);
            1:  v = ZW'(30386);
            2:  v = ZW'(16055);
            3:  v = ZW'(8150);
            4:  v = ZW'(4091);
            5:  v = ZW'(2047);
            6:  v = ZW'(1024);
            7:  v = ZW'(512);
            8:  v = ZW'(256);
            9:  v = ZW'(128);
            10: v = ZW'(64);
            11: v = ZW'(32);
            12: v = ZW'(16);
            13: v = ZW'(8);
            14: v = ZW'(4);
            15: v = ZW'(2);
            16: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/ggc_cordic.sv
// iterative cordic vectoring unit, atan2 in radians, signed 20-bit q4.16
// depends on ggc_pkg
`default_nettype none
module ggc_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [ggc_pkg::CW-1:0]   i_y,
    input  logic signed [ggc_pkg::CW-1:0]   i_x,
    output logic                            o_done,
    output logic signed [ggc_pkg::ZW-1:0]   o_z
);
    import ggc_pkg::*;

    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [CORDIC_IW-1:0] r_i;
    logic r_busy, r_done, r_zero;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] a;
    logic last;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign a = atan_lut(r_i);
    assign last = (r_i == CORDIC_IW'(CORDIC_ITERATIONS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x < 0) begin
                    if (i_y >= 0) begin
                        r_x <= i_y;
                        r_y <= -i_x;
                        r_z <= ZW'(HALF_PI_Q16);
                    end else begin
                        r_x <= -i_y;
                        r_y <= i_x;
                        r_z <= -ZW'(HALF_PI_Q16);
                    end
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + a;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - a;
                end
                r_i <= r_i + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_z = r_zero ? '0 : r_z;
endmodule
`default_nettype wire

FILE: hw/rtl/ggc_isqrt.sv
// bit-pair integer square root, one result bit per cycle
// depends on ggc_pkg
`default_nettype none
module ggc_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ggc_pkg::SQ_W-1:0]    i_n,
    output logic                        o_done,
    output logic [ggc_pkg::SQ_W/2-1:0]  o_root
);
    import ggc_pkg::*;

    logic [SQ_W-1:0] r_n, r_r, r_bit;
    logic [SQ_CW-1:0] r_cnt;
    logic r_busy, r_done;
    logic [SQ_W-1:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n <= i_n;
                r_r <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
                r_cnt <= '0;
            end else if (r_busy) begin
                if (r_n >= trial) begin
                    r_n <= r_n - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_CW'(SQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_W/2-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/go_to_goal_controller_unit.sv
// go-to-goal controller top level: sequencer, shared multiplier and registers
// depends on ggc_pkg, ggc_cordic, ggc_isqrt and assert_macros.svh
// A mode 0 request loads the goal and gives no result. A pose request gives
// one result while a goal is held. A pose that stays unaligned passes
// through the quaternion products on the shared multiplier, two runs of the
// 16-step cordic, the compare, the output and the idle state. A pose that
// becomes aligned adds the 32-step square root and the distance and speed
// products. Once aligned a pose skips the quaternion products and the cordic
// runs. The block accepts nothing while a pose is at work; a finished result
// waits in the output register without blocking the input.
`default_nettype none
`include "assert_macros.svh"
module go_to_goal_controller_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic signed [31:0]              i_goal_x,
    input  logic signed [31:0]              i_goal_y,
    input  logic signed [31:0]              i_pose_x,
    input  logic signed [31:0]              i_pose_y,
    input  logic signed [15:0]              i_quat_x,
    input  logic signed [15:0]              i_quat_y,
    input  logic signed [15:0]              i_quat_z,
    input  logic signed [15:0]              i_quat_w,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [17:0]                     o_linear_speed,
    output logic [15:0]                     o_angular_speed,
    output logic                            o_aligned,
    output logic                            o_arrived,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ggc_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic [ggc_pkg::CFG_DW-1:0]      i_cfg_data
);
    import ggc_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_step;
    logic r_goal_valid, r_head_done, r_pos_done;
    logic [15:0] r_tol, r_gain, r_ofs, r_turn;
    logic [22:0] r_rad;
    logic [17:0] r_max;
    logic signed [31:0] r_gx, r_gy;
    logic signed [32:0] r_dx, r_dy;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [2*MW-1:0] r_prod;
    logic signed [32:0] r_acca, r_accb;
    logic [63:0] r_acc;
    logic signed [ZW-1:0] r_yaw, r_brg;
    logic [30:0] r_ax, r_ay;
    logic r_sh;
    logic [32:0] r_d;
    logic [17:0] r_lin;
    logic [15:0] r_ang;
    logic r_out_valid;
    logic [17:0] r_out_lin;
    logic [15:0] r_out_ang;
    logic r_out_aligned, r_out_arrived;

    logic accept, out_free;
    logic signed [MW-1:0] mul_a, mul_b;
    logic cor_start, cor_done, sq_start, sq_done;
    logic signed [CW-1:0] cor_y, cor_x;
    logic signed [ZW-1:0] cor_z;
    logic [31:0] sq_root;
    logic signed [33:0] t3;
    logic signed [34:0] t4;
    logic signed [ZW:0] diff;
    logic [ZW:0] absd;
    logic aligned_now;
    logic [32:0] ax_full, ay_full;
    logic big;
    logic [33:0] vel;
    logic [17:0] lin_cap;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    assign t3 = $signed({r_acca, 1'b0});
    assign t4 = (35'sd1 <<< 30) - $signed({r_accb[32], r_accb, 1'b0});
    assign diff = (ZW+1)'(r_yaw) - (ZW+1)'(r_brg);
    assign absd = diff[ZW] ? (ZW+1)'(-diff) : (ZW+1)'(diff);
    assign aligned_now = absd < (ZW+1)'(r_tol);
    assign ax_full = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign ay_full = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign big = ax_full[32] | ax_full[31] | ay_full[32] | ay_full[31];
    assign vel = 34'(r_prod[48:16]) + 34'(r_ofs);
    assign lin_cap = (vel > 34'(r_max)) ? r_max : vel[17:0];

    ggc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_y     (cor_y),
        .i_x     (cor_x),
        .o_done  (cor_done),
        .o_z     (cor_z)
    );

    ggc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (r_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_mode && r_goal_valid) begin
                    if (!r_head_done) begin
                        n_state = S_QMUL;
                    end else if (!r_pos_done) begin
                        n_state = S_ABS;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_QMUL: if (r_step == 3'd4) n_state = S_YAW;
            S_YAW:  if (cor_done) n_state = S_BRG;
            S_BRG:  if (cor_done) n_state = S_CMP;
            S_CMP:  n_state = (aligned_now && !r_pos_done) ? S_ABS : S_OUT;
            S_ABS:  n_state = S_MMUL;
            S_MMUL: if (r_step == 3'd2) n_state = S_SQRT;
            S_SQRT: if (sq_done) n_state = S_SPD;
            S_SPD:  if (r_step == 3'd1) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // shared unit operands and unit starts
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        cor_start = 1'b0;
        sq_start = 1'b0;
        cor_y = CW'(r_dy);
        cor_x = CW'(r_dx);
        case (r_state)
            S_QMUL: begin
                case (r_step)
                    3'd0: begin
                        mul_a = MW'(r_qw);
                        mul_b = MW'(r_qz);
                    end
                    3'd1: begin
                        mul_a = MW'(r_qx);
                        mul_b = MW'(r_qy);
                    end
                    3'd2: begin
                        mul_a = MW'(r_qy);
                        mul_b = MW'(r_qy);
                    end
                    3'd3: begin
                        mul_a = MW'(r_qz);
                        mul_b = MW'(r_qz);
                    end
                    default: ;
                endcase
            end
            S_YAW: begin
                cor_y = CW'(t3);
                cor_x = CW'(t4);
                cor_start = (r_step == 3'd0);
            end
            S_BRG: cor_start = (r_step == 3'd0);
            S_MMUL: begin
                if (r_step == 3'd0) begin
                    mul_a = MW'(r_ax);
                    mul_b = MW'(r_ax);
                end else if (r_step == 3'd1) begin
                    mul_a = MW'(r_ay);
                    mul_b = MW'(r_ay);
                end
            end
            S_SQRT: sq_start = (r_step == 3'd0);
            S_SPD: begin
                mul_a = MW'(r_d);
                mul_b = MW'(r_gain);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_goal_valid <= 1'b0;
            r_head_done <= 1'b0;
            r_pos_done <= 1'b0;
            r_gx <= '0;
            r_gy <= '0;
            r_out_valid <= 1'b0;
            r_tol <= 16'd3277;
            r_rad <= 23'd13107;
            r_max <= 18'd32768;
            r_gain <= 16'd6554;
            r_ofs <= 16'd1311;
            r_turn <= 16'd3277;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_step <= '0;
            end else if (r_step != 3'd7) begin
                r_step <= r_step + 1'b1;
            end
            r_prod <= mul_a * mul_b;

            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TOL:  r_tol <= i_cfg_data[15:0];
                    CFG_RAD:  r_rad <= i_cfg_data[22:0];
                    CFG_MAX:  r_max <= i_cfg_data[17:0];
                    CFG_GAIN: r_gain <= i_cfg_data[15:0];
                    CFG_OFS:  r_ofs <= i_cfg_data[15:0];
                    CFG_TURN: r_turn <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!i_mode) begin
                            r_gx <= i_goal_x;
                            r_gy <= i_goal_y;
                            r_goal_valid <= 1'b1;
                            r_head_done <= 1'b0;
                            r_pos_done <= 1'b0;
                        end else begin
                            r_dx <= {r_gx[31], r_gx} - {i_pose_x[31], i_pose_x};
                            r_dy <= {r_gy[31], r_gy} - {i_pose_y[31], i_pose_y};
                            r_qx <= i_quat_x;
                            r_qy <= i_quat_y;
                            r_qz <= i_quat_z;
                            r_qw <= i_quat_w;
                            r_lin <= '0;
                            r_ang <= '0;
                        end
                    end
                end
                S_QMUL: begin
                    case (r_step)
                        3'd1: r_acca <= 33'(r_prod);
                        3'd2: r_acca <= r_acca + 33'(r_prod);
                        3'd3: r_accb <= 33'(r_prod);
                        3'd4: r_accb <= r_accb + 33'(r_prod);
                        default: ;
                    endcase
                end
                S_YAW: if (cor_done) r_yaw <= cor_z;
                S_BRG: if (cor_done) r_brg <= cor_z;
                S_CMP: begin
                    if (aligned_now) begin
                        r_head_done <= 1'b1;
                    end else begin
                        r_ang <= r_turn;
                    end
                end
                S_ABS: begin
                    r_ax <= big ? ax_full[31:1] : ax_full[30:0];
                    r_ay <= big ? ay_full[31:1] : ay_full[30:0];
                    r_sh <= big;
                end
                S_MMUL: begin
                    if (r_step == 3'd1) begin
                        r_acc <= 64'(r_prod);
                    end else if (r_step == 3'd2) begin
                        r_acc <= r_acc + 64'(r_prod);
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_d <= r_sh ? {sq_root, 1'b0} : {1'b0, sq_root};
                    end
                end
                S_SPD: begin
                    if (r_step == 3'd1) begin
                        if (r_d < 33'(r_rad)) begin
                            r_lin <= '0;
                            r_pos_done <= 1'b1;
                        end else begin
                            r_lin <= lin_cap;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_lin <= r_lin;
                        r_out_ang <= r_ang;
                        r_out_aligned <= r_head_done;
                        r_out_arrived <= r_pos_done;
                        if (r_head_done && r_pos_done) begin
                            r_goal_valid <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_linear_speed = r_out_lin;
    assign o_angular_speed = r_out_ang;
    assign o_aligned = r_out_aligned;
    assign o_arrived = r_out_arrived;

    `GGC_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT))
    `GGC_ASSERT_IMP(a_pos_needs_head, i_clk, i_rst_n, r_pos_done, r_head_done)
    `GGC_ASSERT_NXT(a_goal_load, i_clk, i_rst_n, accept && !i_mode, r_goal_valid && !r_head_done && !r_pos_done)
    `GGC_ASSERT_IMP(a_cordic_owner, i_clk, i_rst_n, cor_done, r_state == S_YAW || r_state == S_BRG)
endmodule
`default_nettype wire

FILE: verif/ggc_checker.sv
// checker for the go-to-goal controller: watches the request, result and register channels
// holds its own copy of goal, flags and registers, predicts each result and compares
// depends on ggc_pkg
`timescale 1ns / 100ps
module ggc_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_mode,
    input  logic signed [31:0]         i_goal_x,
    input  logic signed [31:0]         i_goal_y,
    input  logic signed [31:0]         i_pose_x,
    input  logic signed [31:0]         i_pose_y,
    input  logic signed [15:0]         i_quat_x,
    input  logic signed [15:0]         i_quat_y,
    input  logic signed [15:0]         i_quat_z,
    input  logic signed [15:0]         i_quat_w,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [17:0]                i_linear_speed,
    input  logic [15:0]                i_angular_speed,
    input  logic                       i_aligned,
    input  logic                       i_arrived,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [ggc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [ggc_pkg::CFG_DW-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_result_count,
    output int                         o_aligned_count,
    output int                         o_arrived_count
);
    import ggc_pkg::*;

    typedef struct packed {
        logic [17:0] lin;
        logic [15:0] ang;
        logic        aligned;
        logic        arrived;
    } t_motion_cmd;

    localparam longint ATAN_Q16 [0:16] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1
    };

    t_motion_cmd cmd_queue[$];
    logic [15:0] tol_r;
    logic [22:0] radius_r;
    logic [17:0] max_speed_r;
    logic [15:0] gain_r;
    logic [15:0] offset_r;
    logic [15:0] turn_r;
    logic signed [31:0] goal_x_r, goal_y_r;
    logic goal_held, heading_ok, position_ok;

    assign o_pending = cmd_queue.size();

    function automatic longint cordic_angle(input longint y_in, input longint x_in);
        longint x, y, z, t, xs, ys, a;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI_Q16;
            end else begin
                x = -y; y = t; z = -HALF_PI_Q16;
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            a = (i < 17) ? ATAN_Q16[i] : 0;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + a;
            end else begin
                x = x - ys; y = y + xs; z = z - a;
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n_in);
        longint unsigned n, r, b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_pose(output t_motion_cmd cmd);
        longint dx, dy, qx, qy, qz, qw, t3, t4, diff;
        longint unsigned ax, ay, d_len, vel;
        int sh;
        cmd = '0;
        dx = longint'(goal_x_r) - longint'(i_pose_x);
        dy = longint'(goal_y_r) - longint'(i_pose_y);
        if (!heading_ok) begin
            qx = i_quat_x; qy = i_quat_y; qz = i_quat_z; qw = i_quat_w;
            t3 = 2 * (qw * qz + qx * qy);
            t4 = (64'sd1 <<< 30) - 2 * (qy * qy + qz * qz);
            diff = cordic_angle(t3, t4) - cordic_angle(dy, dx);
            if (diff < 0) diff = -diff;
            if (diff < longint'(tol_r)) heading_ok = 1'b1;
            else cmd.ang = turn_r;
        end
        if (!position_ok && heading_ok) begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            sh = 0;
            if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
                ax = ax >> 1; ay = ay >> 1; sh = 1;
            end
            d_len = floor_root(ax * ax + ay * ay) << sh;
            vel = ((d_len * gain_r) >> 16) + offset_r;
            if (vel > max_speed_r) vel = max_speed_r;
            if (d_len < radius_r) begin
                vel = 0;
                position_ok = 1'b1;
            end
            cmd.lin = vel[17:0];
        end
        if (position_ok && heading_ok) goal_held = 1'b0;
        cmd.aligned = heading_ok;
        cmd.arrived = position_ok;
    endtask

    always @(posedge i_clk) begin
        t_motion_cmd exp_cmd, got_cmd;
        if (!i_rst_n) begin
            tol_r <= 16'd3277; radius_r <= 23'd13107; max_speed_r <= 18'd32768;
            gain_r <= 16'd6554; offset_r <= 16'd1311; turn_r <= 16'd3277;
            goal_x_r = '0; goal_y_r = '0;
            goal_held = 1'b0; heading_ok = 1'b0; position_ok = 1'b0;
            cmd_queue.delete();
            o_fail_count <= 0; o_result_count <= 0;
            o_aligned_count <= 0; o_arrived_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TOL:  tol_r <= i_cfg_data[15:0];
                    CFG_RAD:  radius_r <= i_cfg_data[22:0];
                    CFG_MAX:  max_speed_r <= i_cfg_data[17:0];
                    CFG_GAIN: gain_r <= i_cfg_data[15:0];
                    CFG_OFS:  offset_r <= i_cfg_data[15:0];
                    CFG_TURN: turn_r <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (!i_mode) begin
                    goal_x_r = i_goal_x;
                    goal_y_r = i_goal_y;
                    goal_held = 1'b1;
                    heading_ok = 1'b0;
                    position_ok = 1'b0;
                end else if (goal_held) begin
                    predict_pose(exp_cmd);
                    cmd_queue.push_back(exp_cmd);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got_cmd = '{i_linear_speed, i_angular_speed, i_aligned, i_arrived};
                o_result_count <= o_result_count + 1;
                if (i_aligned) o_aligned_count <= o_aligned_count + 1;
                if (i_arrived) o_arrived_count <= o_arrived_count + 1;
                if (cmd_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result lin=%0d ang=%0d al=%0b ar=%0b",
                                 got_cmd.lin, got_cmd.ang, got_cmd.aligned, got_cmd.arrived);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_cmd = cmd_queue.pop_front();
                    if (exp_cmd != got_cmd) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp lin=%0d ang=%0d al=%0b ar=%0b, %s%0d %s%0d %s%0b %s%0b",
                                     exp_cmd.lin, exp_cmd.ang, exp_cmd.aligned, exp_cmd.arrived,
                                     "got lin=", got_cmd.lin, "ang=", got_cmd.ang,
                                     "al=", got_cmd.aligned, "ar=", got_cmd.arrived);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb_go_to_goal_controller_unit.sv
// testbench top for the go-to-goal controller: clock, reset, goal and pose requests,
// register phases and verdict; checking is done by ggc_checker
// depends on ggc_pkg, ggc_checker and go_to_goal_controller_unit
`timescale 1ns / 100ps
module tb_go_to_goal_controller_unit;
    import ggc_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;
    localparam int ITEM_TARGET = 1400;
    localparam int DRAIN_CYCLES = 150;

    logic i_clk, i_rst_n;
    logic in_valid, in_stall, mode;
    logic signed [31:0] goal_x, goal_y, pose_x, pose_y;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic out_valid, out_stall;
    logic [17:0] linear_speed;
    logic [15:0] angular_speed;
    logic aligned, arrived;
    logic cfg_valid, cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int fail_count, pending, result_count, aligned_count, arrived_count;
    int items_sent, cfg_writes, burst_left;
    logic hold_req;
    logic [22:0] radius_now;

    go_to_goal_controller_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_mode(mode),
        .i_goal_x(goal_x), .i_goal_y(goal_y), .i_pose_x(pose_x), .i_pose_y(pose_y),
        .i_quat_x(quat_x), .i_quat_y(quat_y), .i_quat_z(quat_z), .i_quat_w(quat_w),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_linear_speed(linear_speed), .o_angular_speed(angular_speed),
        .o_aligned(aligned), .o_arrived(arrived),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ggc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_mode(mode),
        .i_goal_x(goal_x), .i_goal_y(goal_y), .i_pose_x(pose_x), .i_pose_y(pose_y),
        .i_quat_x(quat_x), .i_quat_y(quat_y), .i_quat_z(quat_z), .i_quat_w(quat_w),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_linear_speed(linear_speed), .i_angular_speed(angular_speed),
        .i_aligned(aligned), .i_arrived(arrived),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count),
        .o_aligned_count(aligned_count), .o_arrived_count(arrived_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stall patterns plus one long hold-off
    initial begin
        int len, pat;
        out_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end
            pat = $urandom_range(0, 2);
            len = $urandom_range(5, 120);
            repeat (len) begin
                case (pat)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 1);
                    default: out_stall <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [31:0] rnd_span(input int bits);
        return $signed($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits);
    endfunction

    task automatic push(input logic m, input logic signed [31:0] gx, gy, px, py,
                        input logic signed [15:0] qx, qy, qz, qw);
        in_valid <= 1'b1;
        mode <= m;
        goal_x <= gx; goal_y <= gy; pose_x <= px; pose_y <= py;
        quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic send_goal(input logic signed [31:0] gx, gy);
        push(1'b0, gx, gy, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_pose(input logic signed [31:0] px, py,
                             input logic signed [15:0] qx, qy, qz, qw);
        push(1'b1, $urandom, $urandom, px, py, qx, qy, qz, qw);
    endtask

    // pose whose yaw points at the goal
    task automatic send_aimed(input logic signed [31:0] px, py, input longint dx, dy);
        real b;
        b = $atan2(real'(dy), real'(dx));
        send_pose(px, py, $urandom_range(0, 3) - 1, $urandom_range(0, 3) - 1,
                  $rtoi($sin(b / 2.0) * 32767.0), $rtoi($cos(b / 2.0) * 32767.0));
    endtask

    task automatic send_noise();
        push($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic approach();
        logic signed [31:0] gx, gy;
        longint ox, oy;
        int r;
        gx = rnd_span(24);
        gy = rnd_span(24);
        ox = rnd_span(22);
        oy = rnd_span(22);
        send_goal(gx, gy);
        repeat ($urandom_range(0, 3))
            send_pose(gx - ox, gy - oy, $urandom, $urandom, $urandom, $urandom);
        send_aimed(gx - ox, gy - oy, ox, oy);
        repeat ($urandom_range(1, 6)) begin
            ox = ox / 2;
            oy = oy / 2;
            send_pose(gx - ox, gy - oy, $urandom, $urandom, $urandom, $urandom);
        end
        r = (radius_now > 8) ? radius_now / 4 : 1;
        ox = $urandom_range(0, r);
        oy = $urandom_range(0, r);
        send_pose(gx - ox, gy - oy, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0)
            send_pose(gx, gy, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_RAD) radius_now = val;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DW-1:0] tol, rad, mx, gain, ofs, turn);
        write_reg(CFG_TOL, tol);
        write_reg(CFG_RAD, rad);
        write_reg(CFG_MAX, mx);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_OFS, ofs);
        write_reg(CFG_TURN, turn);
    endtask

    initial begin
        int phase_end;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0; mode <= 1'b0;
        goal_x <= '0; goal_y <= '0; pose_x <= '0; pose_y <= '0;
        quat_x <= '0; quat_y <= '0; quat_z <= '0; quat_w <= '0;
        cfg_valid <= 1'b0; cfg_index <= CFG_TOL; cfg_data <= '0;
        items_sent = 0; cfg_writes = 0; burst_left = 0;
        hold_req = 1'b0; radius_now = 23'd13107;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pose with no goal, extremes, huge distance, reload, zero vectors
        send_pose(32'sh7fffffff, 32'sh80000000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_goal(32'sh7fffffff, 32'sh7fffffff);
        send_pose(32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_aimed(32'sh80000000, 32'sh80000000, 64'hffffffff, 64'hffffffff);
        send_pose(32'sh80000000, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_goal(32'sh80000000, 32'sh7fffffff);
        send_pose(32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0);
        send_goal(0, 0);
        send_pose(0, 0, 16'sd1000, 16'sd16384, 16'sd16384, -16'sd1000);
        send_pose(0, 0, 0, 0, 0, 16'sh7fff);
        send_goal(32'sd65536, 0);
        send_pose(0, 0, 0, 0, 0, 16'sh7fff);
        send_pose(32'sd60000, 0, 0, 0, 0, 16'sh7fff);
        send_goal(-32'sd65536, 32'sd10);
        send_aimed(0, 0, -64'sd65536, 64'sd10);
        send_goal(32'sd100, -32'sd65536);
        send_aimed(0, 0, 64'sd100, -64'sd65536);
        send_pose(32'sd100, -32'sd65536, 0, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_all(3277, 13107, 32768, 6554, 1311, 3277);
                1: write_all(65535, 4194304, 131072, 65535, 65535, 65535);
                2: begin
                    write_all(0, 0, 0, 0, 0, 0);
                    write_reg(CFG_SPARE_LO, $urandom);
                    write_reg(CFG_SPARE_HI, $urandom);
                end
                3: write_all($urandom_range(1500, 20000), $urandom_range(1000, 300000),
                             $urandom_range(1, 131072), $urandom, $urandom, $urandom);
                default: write_all(6000, 40000, 100000, 30000, 2000, 12000);
            endcase
            if (phase == 1) hold_req = 1'b1;
            phase_end = items_sent + ITEM_TARGET / 5;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0) send_noise();
                else approach();
            end
            drain();
        end

        $display("sent %0d requests over 5 register phases, %0d register writes",
                 items_sent, cfg_writes);
        $display("checked %0d results, %0d aligned, %0d arrived",
                 result_count, aligned_count, arrived_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ggc_pkg.sv
hw/rtl/ggc_cordic.sv
hw/rtl/ggc_isqrt.sv
hw/rtl/go_to_goal_controller_unit.sv
verif/ggc_checker.sv
verif/tb_go_to_goal_controller_unit.sv
